// File: hw/rtl/hex_record_flash_loader_core_macros.svh
// Assertion macros shared by the checker of the record loader.
`ifndef HEX_RECORD_FLASH_LOADER_CORE_MACROS_SVH
`define HEX_RECORD_FLASH_LOADER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HRFL_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HRFL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/hrfl_pkg.sv
// Package with the types and constants of the record loader.
package hrfl_pkg;
   typedef enum logic [2:0] {
      PH_LEN, PH_AHI, PH_ALO, PH_TYPE, PH_DATA, PH_SUM, PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      EMIT_IDLE, EMIT_ERASE, EMIT_PROG, EMIT_STATUS
   } emit_type;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_ERASE  = 2'd1;
   localparam logic [1:0] KIND_PROG   = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FAIL     = 3'd1;
   localparam logic [2:0] ST_EOF      = 3'd2;
   localparam logic [2:0] ST_CHECKSUM = 3'd3;
   localparam logic [2:0] ST_TIMEOUT  = 3'd4;
   localparam logic [2:0] ST_LENGTH   = 3'd5;

   localparam logic [1:0] CSR_APP_START = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_SKIP      = 2'd2;

   localparam logic [31:0] APP_START_RESET = 32'h0800_3000;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd2000;
   localparam logic [1:0]  SKIP_RESET      = 2'd2;

   localparam logic [7:0] REC_DATA   = 8'd0;
   localparam logic [7:0] TYPE_EOF   = 8'd1;
   localparam logic [7:0] TYPE_UPPER = 8'd4;
   localparam logic [7:0] PAD_BYTE   = 8'hFF;
endpackage

// File: hw/rtl/hex_record_flash_loader_core.sv
// Top level of the Intel-HEX record loader with its data record buffer.
//
//  channel | direction | words
//  req_    | in        | kind, byte_value (one byte or one millisecond tick)
//  rsp_    | out       | result_kind, address, halfword, page_count, status, last
//  csr_    | in        | write enable, index, 32-bit data
//
// A byte or tick that causes no result gives no word, and every word taken
// while halted is dropped. A word that ends in a single status word gives only
// that word; an upper address record also makes two buffer reads. An accepted
// data record gives the erase word, then a program word per halfword from two
// buffer reads on the single read port, then the status word. req_ready is low
// while result words are pending. Reset is synchronous; the buffer needs no
// clearing. A stalled rsp_ready holds the current word and the next read.
module hex_record_flash_loader_core #(
   parameter int PAGE_BYTES     = 2048,
   parameter int MAX_DATA_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_address,
   output logic [15:0] rsp_halfword,
   output logic [15:0] rsp_page_count,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int AW = $clog2(MAX_DATA_BYTES);
   localparam int PS = $clog2(PAGE_BYTES);

   logic [31:0] app_start_ff;
   logic [15:0] timeout_ff;
   logic [1:0]  skip_ff;

   hrfl_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] low_ff, low_in;
   logic [15:0] upper_ff, upper_in;
   logic [31:0] erase_ff, erase_in;
   logic        ok_ff, ok_in;
   logic [1:0]  skipped_ff, skipped_in;
   logic [15:0] idle_ff, idle_in;

   // Emission sequencer state.
   hrfl_pkg::emit_type emit_ff, emit_in;
   logic [7:0]  idx_ff, idx_in;
   logic        upper_pend_ff, upper_pend_in;
   logic        rd_pend_ff, rd_pend_in;
   logic [31:0] base_ff, base_in;
   logic [2:0]  st_ff, st_in;
   logic        rv_ff, rv_in;
   logic [1:0]  rk_ff, rk_in;
   logic [31:0] ra_ff, ra_in;
   logic [15:0] rh_ff, rh_in;
   logic [15:0] rp_ff, rp_in;
   logic [2:0]  rs_ff, rs_in;
   logic        rl_ff, rl_in;
   logic [7:0]  lo_byte_ff, lo_byte_in;

   logic [7:0] mem [MAX_DATA_BYTES];
   logic [7:0] rd_data_ff;
   logic       wr_en;
   logic [AW-1:0] wr_addr, rd_addr;

   logic take, skipping, busy;
   logic [32:0] end_addr, diff;
   logic [32:0] pages;
   logic [31:0] rec_addr;

   assign busy      = (emit_ff != hrfl_pkg::EMIT_IDLE) || rv_ff || upper_pend_ff;
   assign req_ready = !busy;
   assign take      = req_valid && req_ready;
   assign skipping  = skipped_ff < skip_ff;
   assign rec_addr  = {upper_ff, low_ff};
   assign end_addr  = {1'b0, rec_addr} + {25'd0, length_ff};
   assign diff      = end_addr - {1'b0, erase_ff} + 33'(PAGE_BYTES - 1);
   assign pages     = (end_addr > {1'b0, erase_ff}) ? (diff >> PS) : 33'd0;

   assign wr_en   = take && !req_kind && phase_ff == hrfl_pkg::PH_DATA && !skipping
                    && count_ff < 8'(MAX_DATA_BYTES);
   assign wr_addr = count_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_byte_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         app_start_ff <= hrfl_pkg::APP_START_RESET;
         timeout_ff   <= hrfl_pkg::TIMEOUT_RESET;
         skip_ff      <= hrfl_pkg::SKIP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            hrfl_pkg::CSR_APP_START: app_start_ff <= csr_data;
            hrfl_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_data[15:0];
            hrfl_pkg::CSR_SKIP:      skip_ff      <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hrfl_pkg::PH_LEN;
         count_ff      <= '0;
         length_ff     <= '0;
         sum_ff        <= '0;
         type_ff       <= '0;
         low_ff        <= '0;
         upper_ff      <= '0;
         erase_ff      <= hrfl_pkg::APP_START_RESET;
         ok_ff         <= 1'b1;
         skipped_ff    <= '0;
         idle_ff       <= '0;
         emit_ff       <= hrfl_pkg::EMIT_IDLE;
         idx_ff        <= '0;
         upper_pend_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rv_ff         <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         length_ff     <= length_in;
         sum_ff        <= sum_in;
         type_ff       <= type_in;
         low_ff        <= low_in;
         upper_ff      <= upper_in;
         erase_ff      <= erase_in;
         ok_ff         <= ok_in;
         skipped_ff    <= skipped_in;
         idle_ff       <= idle_in;
         emit_ff       <= emit_in;
         idx_ff        <= idx_in;
         upper_pend_ff <= upper_pend_in;
         rd_pend_ff    <= rd_pend_in;
         rv_ff         <= rv_in;
      end
      base_ff    <= base_in;
      st_ff      <= st_in;
      rk_ff      <= rk_in;
      ra_ff      <= ra_in;
      rh_ff      <= rh_in;
      rp_ff      <= rp_in;
      rs_ff      <= rs_in;
      rl_ff      <= rl_in;
      lo_byte_ff <= lo_byte_in;
   end

   always_comb begin
      logic [7:0] nsum;
      logic       restart;
      logic [15:0] idle_inc;
      nsum      = sum_ff + req_byte_value;
      restart   = 1'b0;
      idle_inc  = (idle_ff != 16'hFFFF) ? idle_ff + 16'd1 : idle_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      sum_in    = sum_ff;
      type_in   = type_ff;
      low_in    = low_ff;
      upper_in  = upper_ff;
      erase_in  = erase_ff;
      ok_in     = ok_ff;
      skipped_in = skipped_ff;
      idle_in   = idle_ff;
      emit_in   = emit_ff;
      idx_in    = idx_ff;
      upper_pend_in = 1'b0;
      rd_pend_in = 1'b0;
      base_in   = base_ff;
      st_in     = st_ff;
      rd_addr   = idx_ff[AW-1:0];
      rv_in     = rv_ff;
      rk_in = rk_ff; ra_in = ra_ff; rh_in = rh_ff; rp_in = rp_ff;
      rs_in = rs_ff; rl_in = rl_ff;
      lo_byte_in = lo_byte_ff;

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end

      // A pending upper-address update reads buffer entry 1 after entry 0.
      if (upper_pend_ff) begin
         upper_in = {lo_byte_ff, rd_data_ff};
      end

      // Once halted, every word is taken and dropped.
      if (take && phase_ff != hrfl_pkg::PH_HALT) begin
         if (req_kind) begin
            idle_in = idle_inc;
            if (idle_inc >= timeout_ff) begin
               idle_in = '0;
               rv_in = 1'b1; rk_in = hrfl_pkg::KIND_STATUS; ra_in = '0;
               rh_in = '0; rp_in = '0; rl_in = 1'b1;
               if (skipping) begin
                  rs_in = hrfl_pkg::ST_OK;
                  skipped_in = skipped_ff + 2'd1;
                  phase_in = hrfl_pkg::PH_LEN; count_in = '0; sum_in = '0;
               end else begin
                  rs_in = hrfl_pkg::ST_TIMEOUT;
                  restart = 1'b1;
               end
            end
         end else begin
            idle_in = '0;
            sum_in  = nsum;
            unique case (phase_ff)
               hrfl_pkg::PH_LEN: begin
                  length_in = req_byte_value;
                  if (!skipping && req_byte_value > 8'(MAX_DATA_BYTES)) begin
                     rv_in = 1'b1; rk_in = hrfl_pkg::KIND_STATUS; ra_in = '0;
                     rh_in = '0; rp_in = '0; rl_in = 1'b1;
                     rs_in = hrfl_pkg::ST_LENGTH;
                     restart = 1'b1;
                  end else begin
                     phase_in = hrfl_pkg::PH_AHI;
                  end
               end
               hrfl_pkg::PH_AHI: begin
                  low_in = {req_byte_value, 8'd0};
                  phase_in = hrfl_pkg::PH_ALO;
               end
               hrfl_pkg::PH_ALO: begin
                  low_in = {low_ff[15:8], req_byte_value};
                  phase_in = hrfl_pkg::PH_TYPE;
               end
               hrfl_pkg::PH_TYPE: begin
                  type_in = req_byte_value;
                  count_in = '0;
                  phase_in = (length_ff != 8'd0) ? hrfl_pkg::PH_DATA : hrfl_pkg::PH_SUM;
               end
               hrfl_pkg::PH_DATA: begin
                  count_in = count_ff + 8'd1;
                  if (count_ff + 8'd1 >= length_ff) begin
                     phase_in = hrfl_pkg::PH_SUM;
                  end
               end
               hrfl_pkg::PH_SUM: begin
                  rk_in = hrfl_pkg::KIND_STATUS; ra_in = '0; rh_in = '0;
                  rp_in = '0; rl_in = 1'b1;
                  if (skipping) begin
                     rv_in = 1'b1; rs_in = hrfl_pkg::ST_OK;
                     skipped_in = skipped_ff + 2'd1;
                     phase_in = hrfl_pkg::PH_LEN; count_in = '0; sum_in = '0;
                  end else if (nsum != 8'd0) begin
                     rv_in = 1'b1; rs_in = hrfl_pkg::ST_CHECKSUM;
                     restart = 1'b1;
                  end else begin
                     phase_in = hrfl_pkg::PH_LEN; count_in = '0; sum_in = '0;
                     priority if (type_ff == hrfl_pkg::REC_DATA) begin
                        if (rec_addr < app_start_ff) begin
                           rv_in = 1'b1; rs_in = hrfl_pkg::ST_FAIL; ok_in = 1'b0;
                        end else begin
                           rv_in = 1'b1; rk_in = hrfl_pkg::KIND_ERASE;
                           ra_in = erase_ff;
                           rp_in = (pages > 33'd65535) ? 16'hFFFF : pages[15:0];
                           rs_in = hrfl_pkg::ST_OK;
                           erase_in = erase_ff + (pages[31:0] << PS);
                           base_in = rec_addr;
                           ok_in = 1'b1;
                           idx_in = '0;
                           if (length_ff == 8'd0) begin
                              rl_in = 1'b0;
                              emit_in = hrfl_pkg::EMIT_STATUS;
                              st_in = hrfl_pkg::ST_OK;
                           end else begin
                              rl_in = 1'b0;
                              emit_in = hrfl_pkg::EMIT_PROG;
                              rd_addr = '0;
                              rd_pend_in = 1'b1;
                           end
                        end
                     end else if (type_ff == hrfl_pkg::TYPE_EOF) begin
                        rv_in = 1'b1; rs_in = hrfl_pkg::ST_EOF;
                        phase_in = hrfl_pkg::PH_HALT;
                     end else begin
                        rv_in = 1'b1;
                        rs_in = ok_ff ? hrfl_pkg::ST_OK : hrfl_pkg::ST_FAIL;
                        if (type_ff == hrfl_pkg::TYPE_UPPER) begin
                           // Entry 0 is read now, entry 1 next cycle.
                           rd_addr = '0;
                           emit_in = hrfl_pkg::EMIT_IDLE;
                           rd_pend_in = 1'b1;
                           idx_in = 8'd1;
                           emit_in = hrfl_pkg::EMIT_ERASE;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         if (restart) begin
            phase_in = hrfl_pkg::PH_LEN; count_in = '0; length_in = '0;
            sum_in = '0; type_in = '0; low_in = '0; upper_in = '0;
            erase_in = app_start_ff; ok_in = 1'b1; skipped_in = '0; idle_in = '0;
         end
      end

      // Sequencer. EMIT_ERASE here is reused as the upper-address read step.
      unique case (emit_ff)
         hrfl_pkg::EMIT_ERASE: begin
            if (rd_pend_ff) begin
               lo_byte_in = rd_data_ff;
               rd_addr = AW'(1);
               upper_pend_in = 1'b1;
               emit_in = hrfl_pkg::EMIT_IDLE;
            end
         end
         hrfl_pkg::EMIT_PROG: begin
            // Two reads per halfword: low byte, then high byte.
            if (rd_pend_ff) begin
               if (!idx_ff[0]) begin
                  lo_byte_in = rd_data_ff;
                  if (idx_ff + 8'd1 < length_ff) begin
                     idx_in = idx_ff + 8'd1;
                     rd_addr = AW'(idx_ff + 8'd1);
                     rd_pend_in = 1'b1;
                  end else if (!rv_in) begin
                     rv_in = 1'b1; rk_in = hrfl_pkg::KIND_PROG;
                     ra_in = base_ff + {24'd0, idx_ff};
                     rh_in = {hrfl_pkg::PAD_BYTE, rd_data_ff};
                     rp_in = '0; rs_in = hrfl_pkg::ST_OK; rl_in = 1'b0;
                     emit_in = hrfl_pkg::EMIT_STATUS; st_in = hrfl_pkg::ST_OK;
                  end else begin
                     rd_addr = idx_ff[AW-1:0];
                     rd_pend_in = 1'b1;
                  end
               end else if (!rv_in) begin
                  rv_in = 1'b1; rk_in = hrfl_pkg::KIND_PROG;
                  ra_in = base_ff + {24'd0, idx_ff} - 32'd1;
                  rh_in = {rd_data_ff, lo_byte_ff};
                  rp_in = '0; rs_in = hrfl_pkg::ST_OK; rl_in = 1'b0;
                  if (idx_ff + 8'd1 < length_ff) begin
                     idx_in = idx_ff + 8'd1;
                     rd_addr = AW'(idx_ff + 8'd1);
                     rd_pend_in = 1'b1;
                  end else begin
                     emit_in = hrfl_pkg::EMIT_STATUS; st_in = hrfl_pkg::ST_OK;
                  end
               end else begin
                  rd_addr = idx_ff[AW-1:0];
                  rd_pend_in = 1'b1;
               end
            end
         end
         hrfl_pkg::EMIT_STATUS: begin
            if (!rv_in) begin
               rv_in = 1'b1; rk_in = hrfl_pkg::KIND_STATUS; ra_in = '0; rh_in = '0;
               rp_in = '0; rs_in = st_ff; rl_in = 1'b1;
               emit_in = hrfl_pkg::EMIT_IDLE;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rv_ff;
   assign rsp_result_kind = rk_ff;
   assign rsp_address     = ra_ff;
   assign rsp_halfword    = rh_ff;
   assign rsp_page_count  = rp_ff;
   assign rsp_status      = rs_ff;
   assign rsp_last        = rl_ff;
endmodule

// File: hw/rtl/hrfl_checker.sv
// Port checker for the record loader, bound to its top level.
`include "hex_record_flash_loader_core_macros.svh"
module hrfl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [2:0]  rsp_status,
   input logic        rsp_last
);
   `HRFL_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_kind))
   `HRFL_ASSERT_IMP(status_range, clock, reset, rsp_valid, rsp_status <= 3'd5)
   `HRFL_ASSERT_IMP(kind_range, clock, reset, rsp_valid, rsp_result_kind != 2'd3)
   `HRFL_ASSERT_IMP(nonstatus_not_last, clock, reset, rsp_valid && rsp_result_kind != 2'd0, !rsp_last)
   `HRFL_ASSERT_IMP(no_take_while_rsp, clock, reset, rsp_valid, !(req_valid && req_ready))
endmodule

bind hex_record_flash_loader_core hrfl_checker u_hrfl_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_kind(rsp_result_kind),
   .rsp_status(rsp_status), .rsp_last(rsp_last)
);
